FILE: src/bdb_pkg.sv
// Shared constants, codes and types for the B-spline de Boor evaluator.
// Used by the top level, the weight divider and the port checker.
package bdb_pkg;

	localparam int MAX_KNOTS  = 32;
	localparam int MAX_DEGREE = 7;
	localparam int MAX_DIM    = 4;
	localparam int FRAC_BITS  = 16;
	localparam int CTRL_DEPTH = 128;
	localparam int CTRL_AW    = 7;

	localparam logic [1:0] MODE_KNOT = 2'd0;
	localparam logic [1:0] MODE_CTRL = 2'd1;
	localparam logic [1:0] MODE_EVAL = 2'd2;

	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_RANGE = 2'd1;
	localparam logic [1:0] ERR_SPAN  = 2'd2;

	localparam logic [1:0] CFG_DEGREE = 2'd0;
	localparam logic [1:0] CFG_DIM    = 2'd1;
	localparam logic [1:0] CFG_KNOTS  = 2'd2;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

FILE: src/bdb_div.sv
// Restoring divider for the blend weight, one quotient bit per cycle.
// Depends on bdb_pkg for the status struct and default fraction width.
module bdb_div #(
	parameter int FRAC_BITS = bdb_pkg::FRAC_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [33+FRAC_BITS-1:0] num,
	input  logic [31:0]            den,
	output bdb_pkg::div_stat_t     stat,
	output logic [FRAC_BITS:0]     quot
);
	localparam int DW = 33 + FRAC_BITS;
	localparam int CW = $clog2(FRAC_BITS + 1);

	logic [DW-1:0]      rem_q;
	logic [DW-1:0]      den_q;
	logic [FRAC_BITS:0] q_q;
	logic [CW-1:0]      cnt_q;
	logic               busy_q;
	logic               done_q;
	logic               ge;

	assign ge = rem_q >= den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			q_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= num;
				den_q  <= DW'(den) << FRAC_BITS;
				cnt_q  <= CW'(FRAC_BITS);
				q_q    <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (ge) begin
					rem_q <= rem_q - den_q;
				end
				den_q <= den_q >> 1;
				q_q   <= {q_q[FRAC_BITS-1:0], ge};
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = q_q;

endmodule

FILE: src/bspline_de_boor_evaluator_top.sv
// B-spline curve evaluator by de Boor's recurrence, Q16.16 fixed point.
// Flow: a knot search, a load of the control coordinates, then for each level step
// two knot reads, the weight divide when the divider runs, and a blend per coordinate.
// Input stalls during an evaluation, so one is in flight at a time; knot and control loads leave input open.
// Reset: arst_n clears control and restores degree 3, dimension 2, knot_count 8;
// knot, control and working stores are undefined until written. Uses bdb_pkg, bdb_div.
module bspline_de_boor_evaluator_top #(
	parameter int MAX_KNOTS  = bdb_pkg::MAX_KNOTS,
	parameter int MAX_DEGREE = bdb_pkg::MAX_DEGREE,
	parameter int MAX_DIM    = bdb_pkg::MAX_DIM,
	parameter int FRAC_BITS  = bdb_pkg::FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         mode,
	input  logic [6:0]         index,
	input  logic signed [31:0] value,
	input  logic signed [31:0] param_t,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         component,
	output logic signed [31:0] coordinate,
	output logic               last,
	output logic [1:0]         error,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	localparam int KW       = $clog2(MAX_KNOTS);
	localparam int KCW      = $clog2(MAX_KNOTS + 1);
	localparam int PW       = $clog2(MAX_DEGREE + 1);
	localparam int DMW      = $clog2(MAX_DIM + 1);
	localparam int WP_DEPTH = (MAX_DEGREE + 1) * MAX_DIM;
	localparam int WPA      = $clog2(WP_DEPTH);
	localparam int WW       = FRAC_BITS + 1;
	localparam int DW       = 33 + FRAC_BITS;
	localparam int SW       = KCW + PW + 1;
	localparam int CAW      = bdb_pkg::CTRL_AW;
	localparam int MW       = SW + DMW + CAW;
	localparam int PRW      = 35 + FRAC_BITS;

	localparam logic signed [PRW-1:0] HALF = PRW'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [PRW:0]   SMAX = (PRW+1)'(32'sh7fffffff);
	localparam logic signed [PRW:0]   SMIN = -SMAX - (PRW+1)'(1);
	localparam logic [WW-1:0]         ONE  = WW'(1) << FRAC_BITS;

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_SR0A = 5'd1;
	localparam logic [4:0] S_SR0U = 5'd2;
	localparam logic [4:0] S_SRA  = 5'd3;
	localparam logic [4:0] S_SRU  = 5'd4;
	localparam logic [4:0] S_RUNA = 5'd5;
	localparam logic [4:0] S_RUNU = 5'd6;
	localparam logic [4:0] S_CHK  = 5'd7;
	localparam logic [4:0] S_LDA  = 5'd8;
	localparam logic [4:0] S_LDU  = 5'd9;
	localparam logic [4:0] S_KLA  = 5'd10;
	localparam logic [4:0] S_KLU  = 5'd11;
	localparam logic [4:0] S_KHA  = 5'd12;
	localparam logic [4:0] S_KHU  = 5'd13;
	localparam logic [4:0] S_DIV  = 5'd14;
	localparam logic [4:0] S_B0A  = 5'd15;
	localparam logic [4:0] S_B0U  = 5'd16;
	localparam logic [4:0] S_B1A  = 5'd17;
	localparam logic [4:0] S_B1U  = 5'd18;
	localparam logic [4:0] S_MUL  = 5'd19;
	localparam logic [4:0] S_BWR  = 5'd20;
	localparam logic [4:0] S_OA   = 5'd21;
	localparam logic [4:0] S_OU   = 5'd22;
	localparam logic [4:0] S_ERR  = 5'd23;

	logic [4:0]               state_q;
	logic [2:0]               cfg_deg_q;
	logic [2:0]               cfg_dim_q;
	logic [5:0]               cfg_kc_q;
	logic signed [31:0]       t_q;
	logic [KCW-1:0]           k_q;
	logic [PW-1:0]            p_q;
	logic [DMW-1:0]           d_q;
	logic [KCW-1:0]           i_q;
	logic [KCW-1:0]           j_q;
	logic [KCW-1:0]           span_q;
	logic signed [31:0]       prev_q;
	logic signed [31:0]       base_q;
	logic signed [31:0]       lo_q;
	logic [1:0]               err_q;
	logic [WPA:0]             n_q;
	logic [WPA:0]             nmax_q;
	logic [WPA:0]             ptr_q;
	logic [CAW-1:0]           cbase_q;
	logic [PW-1:0]            lvl_q;
	logic [PW-1:0]            ii_q;
	logic [DMW-1:0]           c_q;
	logic [KW-1:0]            klo_q;
	logic [KW-1:0]            khi_q;
	logic [WW-1:0]            w_q;
	logic signed [31:0]       p0_q;
	logic signed [31:0]       p1_q;
	logic signed [PRW-1:0]    prod_q;
	logic                     oval_q;
	logic [1:0]               ocomp_q;
	logic signed [31:0]       ocoord_q;
	logic                     olast_q;
	logic [1:0]               oerr_q;

	logic signed [31:0]       knot_mem [MAX_KNOTS];
	logic signed [31:0]       ctrl_mem [bdb_pkg::CTRL_DEPTH];
	logic signed [31:0]       wp_mem [WP_DEPTH];
	logic signed [31:0]       krd_q;
	logic signed [31:0]       crd_q;
	logic signed [31:0]       wrd_q;

	logic                     in_acc;
	logic                     out_free;
	logic                     out_load;
	logic [KW-1:0]            kaddr;
	logic [CAW-1:0]           caddr;
	logic [WPA-1:0]           wp_ra;
	logic                     wp_we;
	logic [WPA-1:0]           wp_wa;
	logic signed [31:0]       wp_wd;
	logic [PW-1:0]            deg_c;
	logic [DMW-1:0]           dim_c;
	logic [KCW-1:0]           kc_c;
	logic                     hit_c;
	logic [KCW-1:0]           spn_c;
	logic                     bad_c;
	logic [MW-1:0]            cb_c;
	logic [WPA:0]             nmax_c;
	logic signed [32:0]       len_c;
	logic signed [32:0]       dist_c;
	logic [DW-1:0]            num_c;
	logic                     div_start;
	bdb_pkg::div_stat_t       div_stat;
	logic [FRAC_BITS:0]       div_q;
	logic signed [32:0]       diff_c;
	logic signed [PRW-1:0]    prod_c;
	logic signed [PRW-1:0]    sh_c;
	logic signed [PRW:0]      sum_c;
	logic signed [31:0]       blend_c;
	logic                     c_last;

	assign in_acc    = in_valid && !in_stall;
	assign in_stall  = state_q != S_IDLE;
	assign out_free  = !oval_q || !out_stall;
	assign out_load  = out_free && (state_q == S_OU || state_q == S_ERR);
	assign cfg_ready = 1'b1;
	assign c_last    = c_q == d_q - 1'b1;

	always_comb begin
		if (cfg_deg_q == '0) begin
			deg_c = PW'(1);
		end else if (32'(cfg_deg_q) > MAX_DEGREE) begin
			deg_c = PW'(MAX_DEGREE);
		end else begin
			deg_c = PW'(cfg_deg_q);
		end
		if (cfg_dim_q == '0) begin
			dim_c = DMW'(1);
		end else if (32'(cfg_dim_q) > MAX_DIM) begin
			dim_c = DMW'(MAX_DIM);
		end else begin
			dim_c = DMW'(cfg_dim_q);
		end
		if (32'(cfg_kc_q) > MAX_KNOTS) begin
			kc_c = KCW'(MAX_KNOTS);
		end else begin
			kc_c = KCW'(cfg_kc_q);
		end
	end

	always_comb begin
		case (state_q)
			S_SRA:   kaddr = KW'(i_q + 1'b1);
			S_RUNA:  kaddr = KW'(j_q + 1'b1);
			S_KLA:   kaddr = klo_q;
			S_KHA:   kaddr = khi_q;
			default: kaddr = '0;
		endcase
		case (state_q)
			S_B1A:   wp_ra = WPA'(ptr_q + (WPA+1)'(d_q));
			S_OA,
			S_OU:    wp_ra = WPA'(c_q);
			default: wp_ra = WPA'(ptr_q);
		endcase
		caddr = cbase_q + CAW'(n_q);
	end

	assign hit_c  = (t_q >= prev_q) && (t_q <= krd_q);
	assign spn_c  = ((KCW+1)'(j_q) + (KCW+1)'(2) == (KCW+1)'(k_q)) ? i_q : j_q;
	assign bad_c  = (SW'(spn_c) < SW'(p_q)) ||
	                (SW'(spn_c) + SW'(p_q) + SW'(1) >= SW'(k_q));
	assign cb_c   = MW'(SW'(spn_c) - SW'(p_q)) * MW'(d_q);
	assign nmax_c = ((WPA+1)'(p_q) + (WPA+1)'(1)) * (WPA+1)'(d_q);

	assign len_c     = 33'(krd_q) - 33'(lo_q);
	assign dist_c    = 33'(t_q) - 33'(lo_q);
	assign num_c     = (DW'(dist_c[31:0]) << FRAC_BITS) + DW'(len_c[32:1]);
	assign div_start = (state_q == S_KHU) && (len_c > 0) && (dist_c > 0) &&
	                   (dist_c < len_c);

	bdb_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (num_c),
		.den   (len_c[31:0]),
		.stat  (div_stat),
		.quot  (div_q)
	);

	assign diff_c  = 33'(p1_q) - 33'(p0_q);
	assign prod_c  = PRW'(diff_c) * $signed(PRW'(w_q));
	assign sh_c    = (prod_q + HALF) >>> FRAC_BITS;
	assign sum_c   = (PRW+1)'(sh_c) + (PRW+1)'(p0_q);
	assign blend_c = (sum_c > SMAX) ? 32'sh7fffffff :
	                 (sum_c < SMIN) ? 32'sh80000000 : sum_c[31:0];

	always_comb begin
		wp_we = 1'b0;
		wp_wa = WPA'(n_q);
		wp_wd = crd_q;
		if (state_q == S_LDU) begin
			wp_we = 1'b1;
		end else if (state_q == S_BWR) begin
			wp_we = 1'b1;
			wp_wa = WPA'(ptr_q);
			wp_wd = blend_c;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && mode == bdb_pkg::MODE_KNOT && 32'(index) < MAX_KNOTS) begin
			knot_mem[KW'(index)] <= value;
		end
		krd_q <= knot_mem[kaddr];
	end

	always_ff @(posedge clk) begin
		if (in_acc && mode == bdb_pkg::MODE_CTRL) begin
			ctrl_mem[CAW'(index)] <= value;
		end
		crd_q <= ctrl_mem[caddr];
	end

	always_ff @(posedge clk) begin
		if (wp_we) begin
			wp_mem[wp_wa] <= wp_wd;
		end
		wrd_q <= wp_mem[wp_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_deg_q <= 3'd3;
			cfg_dim_q <= 3'd2;
			cfg_kc_q  <= 6'd8;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bdb_pkg::CFG_DEGREE: cfg_deg_q <= cfg_data[2:0];
				bdb_pkg::CFG_DIM:    cfg_dim_q <= cfg_data[2:0];
				bdb_pkg::CFG_KNOTS:  cfg_kc_q  <= cfg_data[5:0];
				default:             ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			oval_q  <= 1'b0;
			err_q   <= bdb_pkg::ERR_NONE;
		end else begin
			if (out_load) begin
				oval_q <= 1'b1;
			end else if (!out_stall) begin
				oval_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc && mode == bdb_pkg::MODE_EVAL) begin
						t_q     <= param_t;
						k_q     <= kc_c;
						p_q     <= deg_c;
						d_q     <= dim_c;
						state_q <= S_SR0A;
					end
				end
				S_SR0A: state_q <= S_SR0U;
				S_SR0U: begin
					prev_q <= krd_q;
					i_q    <= '0;
					if (k_q < KCW'(2)) begin
						err_q   <= bdb_pkg::ERR_RANGE;
						state_q <= S_ERR;
					end else begin
						state_q <= S_SRA;
					end
				end
				S_SRA: state_q <= S_SRU;
				S_SRU: begin
					if (hit_c) begin
						base_q  <= prev_q;
						j_q     <= i_q;
						state_q <= S_RUNA;
					end else if ((KCW+1)'(i_q) + (KCW+1)'(2) < (KCW+1)'(k_q)) begin
						prev_q  <= krd_q;
						i_q     <= i_q + 1'b1;
						state_q <= S_SRA;
					end else begin
						err_q   <= bdb_pkg::ERR_RANGE;
						state_q <= S_ERR;
					end
				end
				S_RUNA: begin
					if ((KCW+1)'(j_q) + (KCW+1)'(1) < (KCW+1)'(k_q)) begin
						state_q <= S_RUNU;
					end else begin
						state_q <= S_CHK;
					end
				end
				S_RUNU: begin
					if (krd_q == base_q) begin
						j_q     <= j_q + 1'b1;
						state_q <= S_RUNA;
					end else begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					span_q  <= spn_c;
					cbase_q <= cb_c[CAW-1:0];
					nmax_q  <= nmax_c;
					n_q     <= '0;
					if (bad_c) begin
						err_q   <= bdb_pkg::ERR_SPAN;
						state_q <= S_ERR;
					end else begin
						state_q <= S_LDA;
					end
				end
				S_LDA: state_q <= S_LDU;
				S_LDU: begin
					n_q <= n_q + 1'b1;
					if (n_q + 1'b1 == nmax_q) begin
						lvl_q   <= p_q;
						ii_q    <= '0;
						ptr_q   <= '0;
						c_q     <= '0;
						klo_q   <= KW'(SW'(span_q) + SW'(1) - SW'(p_q));
						khi_q   <= KW'(span_q + 1'b1);
						state_q <= S_KLA;
					end else begin
						state_q <= S_LDA;
					end
				end
				S_KLA: state_q <= S_KLU;
				S_KLU: begin
					lo_q    <= krd_q;
					state_q <= S_KHA;
				end
				S_KHA: state_q <= S_KHU;
				S_KHU: begin
					if (len_c <= 0) begin
						err_q   <= bdb_pkg::ERR_SPAN;
						state_q <= S_ERR;
					end else if (dist_c <= 0) begin
						w_q     <= '0;
						state_q <= S_B0A;
					end else if (dist_c >= len_c) begin
						w_q     <= ONE;
						state_q <= S_B0A;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_stat.done && !div_stat.busy) begin
						w_q     <= div_q;
						state_q <= S_B0A;
					end
				end
				S_B0A: state_q <= S_B0U;
				S_B0U: begin
					p0_q    <= wrd_q;
					state_q <= S_B1A;
				end
				S_B1A: state_q <= S_B1U;
				S_B1U: begin
					p1_q    <= wrd_q;
					state_q <= S_MUL;
				end
				S_MUL: begin
					prod_q  <= prod_c;
					state_q <= S_BWR;
				end
				S_BWR: begin
					ptr_q <= ptr_q + 1'b1;
					if (c_last) begin
						c_q <= '0;
						if (ii_q + 1'b1 == lvl_q) begin
							if (lvl_q == PW'(1)) begin
								state_q <= S_OA;
							end else begin
								lvl_q   <= lvl_q - 1'b1;
								ii_q    <= '0;
								ptr_q   <= '0;
								klo_q   <= KW'(SW'(span_q) + SW'(2) - SW'(lvl_q));
								khi_q   <= KW'(span_q + 1'b1);
								state_q <= S_KLA;
							end
						end else begin
							ii_q    <= ii_q + 1'b1;
							klo_q   <= klo_q + 1'b1;
							khi_q   <= khi_q + 1'b1;
							state_q <= S_KLA;
						end
					end else begin
						c_q     <= c_q + 1'b1;
						state_q <= S_B0A;
					end
				end
				S_OA: state_q <= S_OU;
				S_OU: begin
					if (out_free) begin
						ocomp_q  <= c_q[1:0];
						ocoord_q <= wrd_q;
						olast_q  <= c_last;
						oerr_q   <= bdb_pkg::ERR_NONE;
						if (c_last) begin
							state_q <= S_IDLE;
						end else begin
							c_q     <= c_q + 1'b1;
							state_q <= S_OA;
						end
					end
				end
				S_ERR: begin
					if (out_free) begin
						ocomp_q  <= 2'd0;
						ocoord_q <= '0;
						olast_q  <= 1'b1;
						oerr_q   <= err_q;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid  = oval_q;
	assign component  = ocomp_q;
	assign coordinate = ocoord_q;
	assign last       = olast_q;
	assign error      = oerr_q;

endmodule

FILE: src/bdb_chk.sv
// Port checker for the B-spline de Boor evaluator, bound to the top level.
// Depends on bdb_pkg for mode and error codes.
module bdb_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic [1:0]         mode,
	input logic               out_valid,
	input logic               out_stall,
	input logic [1:0]         component,
	input logic signed [31:0] coordinate,
	input logic               last,
	input logic [1:0]         error
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(coordinate) && $stable(last))
		else $error("stalled result changed");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error != bdb_pkg::ERR_NONE |-> last)
		else $error("flagged result not marked last");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error != bdb_pkg::ERR_NONE |-> component == 2'd0 && coordinate == 0)
		else $error("flagged result carries data");

	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && mode == bdb_pkg::MODE_EVAL |=> in_stall)
		else $error("evaluate transfer did not hold off input");

endmodule

bind bspline_de_boor_evaluator_top bdb_chk u_chk (.*);
